// File: rtl/gtd_pkg.sv
package gtd_pkg;

  // widths fixed by the field and state definitions
  localparam int unsigned S_W       = 48;
  localparam int unsigned E_W       = 48;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned PAT_W     = 32;
  localparam int unsigned PAT_IDX_W = 5;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CS_W      = 64;
  localparam int unsigned MAG_W     = 112;
  localparam int unsigned ACC_W     = 128;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned OUT_W     = 72;

  localparam logic [THR_W-1:0]   THR_RESET   = 32'h0001_0000;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF    = 3'd0,
    REG_INIT_THR = 3'd1,
    REG_SHIFT    = 3'd2,
    REG_TARGET   = 3'd3,
    REG_LENGTH   = 3'd4,
    REG_MAXD     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_S1S1,
    MUL_S2S2,
    MUL_CS_S2
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMP,
    ST_MS1,
    ST_SQ1,
    ST_SQ2,
    ST_CS,
    ST_CROSS,
    ST_DIVS,
    ST_DIV,
    ST_UPD,
    ST_CHK,
    ST_EDIT,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     load_sample;
    logic     upd_sample;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     acc_sub;
    logic     load_cs;
    logic     div_start;
    logic     blk_update;
    logic     ed_start;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic mul_busy;
    logic div_busy;
    logic ed_busy;
    logic ed_need;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/gtd_edit.sv
module gtd_edit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gtd_pkg::POS_W-1:0] len_i,
  input  logic [gtd_pkg::PAT_W-1:0] target_i,
  input  logic [gtd_pkg::PAT_W-1:0] observed_i,
  output logic                      busy_o,
  output logic [gtd_pkg::POS_W-1:0] dist_o
);
  import gtd_pkg::*;

  // previous DP row kept as a queue of len+1 entries, head at index 0
  logic [POS_W-1:0]     line_q [PAT_W+1];
  logic [POS_W-1:0]     line_d [PAT_W+1];
  logic [POS_W-1:0]     i_q, i_d, j_q, j_d, diag_q, diag_d, left_q, left_d;
  logic                 busy_q, busy_d;
  logic [PAT_IDX_W-1:0] ai, bj;
  logic [POS_W:0]       cost, up1, left1, best;
  logic [POS_W-1:0]     push_v;

  assign ai    = i_q[PAT_IDX_W-1:0] - 1'b1;
  assign bj    = j_q[PAT_IDX_W-1:0] - 1'b1;
  assign cost  = {1'b0, diag_q} + {{POS_W{1'b0}}, (target_i[ai] != observed_i[bj])};
  assign up1   = {1'b0, line_q[0]} + 1'b1;
  assign left1 = {1'b0, left_q} + 1'b1;

  always_comb begin
    best = cost;
    if (up1 < best) best = up1;
    if (left1 < best) best = left1;
  end

  assign push_v = (j_q == '0) ? i_q : best[POS_W-1:0];

  always_comb begin
    for (int k = 0; k <= PAT_W; k++) begin
      line_d[k] = line_q[k];
    end
    i_d    = i_q;
    j_d    = j_q;
    diag_d = diag_q;
    left_d = left_q;
    busy_d = busy_q;
    if (start_i) begin
      for (int k = 0; k <= PAT_W; k++) begin
        line_d[k] = POS_W'(k);
      end
      i_d    = POS_W'(1);
      j_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int k = 0; k < PAT_W; k++) begin
        line_d[k] = (POS_W'(k) == len_i) ? push_v : line_q[k+1];
      end
      line_d[PAT_W] = (POS_W'(PAT_W) == len_i) ? push_v : line_q[PAT_W];
      if (j_q == '0) begin
        diag_d = line_q[0];
        left_d = i_q;
        j_d    = POS_W'(1);
      end else begin
        diag_d = line_q[0];
        left_d = best[POS_W-1:0];
        if (j_q == len_i) begin
          j_d = '0;
          if (i_q == len_i) begin
            busy_d = 1'b0;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    i_q    <= i_d;
    j_q    <= j_d;
    diag_q <= diag_d;
    left_q <= left_d;
  end

  assign busy_o = busy_q;
  assign dist_o = left_q;

endmodule

// File: rtl/gtd_datapath.sv
module gtd_datapath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_BLOCK   = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [gtd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gtd_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  input  gtd_pkg::dp_cmd_t              cmd_i,
  output gtd_pkg::dp_status_t           status_o,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic                          tone_o,
  output logic [gtd_pkg::THR_W-1:0]     ratio_o,
  output logic [gtd_pkg::THR_W-1:0]     thr_o,
  output logic                          matched_o,
  output logic                          missed_o,
  output logic                          rearmed_o
);
  import gtd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK);
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;

  // configuration
  logic signed [COEFF_W-1:0] coeff_q;
  logic [SHIFT_W-1:0]        shift_q;
  logic [PAT_W-1:0]          target_q;
  logic [POS_W-1:0]          plen_q, maxd_q;
  logic                      wr_init_thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q    <= '0;
      shift_q    <= SHIFT_RESET;
      target_q   <= PAT_W'(1);
      plen_q     <= POS_W'(1);
      maxd_q     <= POS_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COEFF:    coeff_q    <= cfg_data_i[COEFF_W-1:0];
        // loads the running threshold directly, see below
        REG_INIT_THR: ;
        REG_SHIFT:    shift_q    <= cfg_data_i[SHIFT_W-1:0];
        REG_TARGET:   target_q   <= cfg_data_i[PAT_W-1:0];
        REG_LENGTH:   plen_q     <= cfg_data_i[POS_W-1:0];
        REG_MAXD:     maxd_q     <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_init_thr = cfg_valid_i && (cfg_reg_e'(cfg_index_i) == REG_INIT_THR);

  // per-sample Goertzel step: products are registered first, then the recurrence sums are formed from them
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          last_q;
  logic signed [CS_W-1:0]        cs_q, cs_mul;
  logic signed [SQ_W-1:0]        sq_q, sq_mul;
  logic signed [S_W-1:0]         s1_q, s2_q, s_sat;
  logic [E_W-1:0]                e_q, e_sat;
  logic [CNT_W-1:0]              cnt_q;
  logic signed [S_W+2:0]         s_sum;
  logic [E_W:0]                  e_sum;
  logic                          blk_update;

  assign cs_mul = coeff_q * s1_q;
  assign sq_mul = sample_i * sample_i;
  assign s_sum  = (S_W+3)'(x_q) + (S_W+3)'($signed(cs_q[CS_W-1:14])) - (S_W+3)'(s2_q);
  assign e_sum  = {1'b0, e_q} + (E_W+1)'(unsigned'(sq_q));

  always_comb begin
    if (s_sum > (S_W+3)'(signed'({1'b0, {(S_W-1){1'b1}}}))) begin
      s_sat = {1'b0, {(S_W-1){1'b1}}};
    end else if (s_sum < -((S_W+3)'(signed'({1'b0, 1'b1, {(S_W-1){1'b0}}})))) begin
      s_sat = {1'b1, {(S_W-1){1'b0}}};
    end else begin
      s_sat = s_sum[S_W-1:0];
    end
    e_sat = e_sum[E_W] ? '1 : e_sum[E_W-1:0];
  end

  assign blk_update = cmd_i.blk_update;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      x_q    <= sample_i;
      last_q <= last_i;
      sq_q   <= sq_mul;
    end
    if (cmd_i.load_sample || cmd_i.load_cs) begin
      cs_q <= cs_mul;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      e_q   <= '0;
      cnt_q <= '0;
    end else if (blk_update) begin
      s1_q  <= '0;
      s2_q  <= '0;
      e_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.upd_sample) begin
      s1_q  <= s_sat;
      s2_q  <= s1_q;
      e_q   <= e_sat;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // shift-add multiplier, one bit of the 48 bit operand per cycle
  logic [CS_W-1:0]       ma_q, mhi_q;
  logic [S_W-1:0]        mlo_q;
  logic                  mneg_q, mbusy_q;
  logic [5:0]            mcnt_q;
  logic signed [CS_W-1:0] op_a;
  logic signed [S_W-1:0]  op_b;
  logic [CS_W:0]         msum;
  logic [MAG_W-1:0]      mag;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_S1S1: begin op_a = CS_W'(s1_q); op_b = s1_q; end
      MUL_S2S2: begin op_a = CS_W'(s2_q); op_b = s2_q; end
      default:  begin op_a = cs_q;        op_b = s2_q; end
    endcase
  end

  assign msum = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, ma_q} : '0);
  assign mag  = {mhi_q, mlo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
    end else if (mbusy_q && (mcnt_q == 6'(S_W - 1))) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q   <= op_a[CS_W-1] ? unsigned'(-op_a) : unsigned'(op_a);
      mlo_q  <= op_b[S_W-1] ? unsigned'(-op_b) : unsigned'(op_b);
      mneg_q <= op_a[CS_W-1] ^ op_b[S_W-1];
      mhi_q  <= '0;
      mcnt_q <= '0;
    end else if (mbusy_q) begin
      mhi_q  <= msum[CS_W:1];
      mlo_q  <= {msum[0], mlo_q[S_W-1:1]};
      mcnt_q <= mcnt_q + 1'b1;
    end
  end

  // tone power accumulator, 128 bit wrap-around
  logic [ACC_W-1:0] p_q, p_add;

  assign p_add = p_q + ACC_W'(mag);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      p_q <= ACC_W'(mag);
    end else if (cmd_i.acc_add) begin
      p_q <= p_add << 14;
    end else if (cmd_i.acc_sub) begin
      p_q <= mneg_q ? p_add : p_q - ACC_W'(mag);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [ACC_W-1:0] dn_q;
  logic [E_W-1:0]   dr_q;
  logic [THR_W-1:0] dq_q, ratio;
  logic             dsat_q, dbusy_q;
  logic [6:0]       dcnt_q;
  logic [E_W:0]     dr2, dsub;
  logic             dge;

  assign dr2   = {dr_q, dn_q[ACC_W-1]};
  assign dsub  = dr2 - {1'b0, e_q};
  assign dge   = dr2 >= {1'b0, e_q};
  assign ratio = dsat_q ? '1 : dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= (e_q != '0) && !p_q[ACC_W-1];
    end else if (dbusy_q && (dcnt_q == 7'(ACC_W - 1))) begin
      dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dn_q   <= {p_q[ACC_W-3:0], 2'b00};
      dr_q   <= '0;
      dq_q   <= '0;
      dsat_q <= 1'b0;
      dcnt_q <= '0;
    end else if (dbusy_q) begin
      dn_q   <= {dn_q[ACC_W-2:0], 1'b0};
      dr_q   <= dge ? dsub[E_W-1:0] : dr2[E_W-1:0];
      dq_q   <= {dq_q[THR_W-2:0], dge};
      dsat_q <= dsat_q | dq_q[THR_W-1];
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // threshold adaptation
  logic [THR_W-1:0]   thr_q, thr_d;
  logic [SHIFT_W-1:0] k;
  logic               tone;

  assign k    = (shift_q == '0) ? SHIFT_W'(1) : shift_q;
  assign tone = ratio > thr_q;

  always_comb begin
    if (tone) begin
      thr_d = thr_q + ((ratio - thr_q) >> (k - 1'b1));
    end else begin
      thr_d = thr_q - ((thr_q - ratio) >> k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (wr_init_thr) begin
      thr_q <= cfg_data_i[THR_W-1:0];
    end else if (blk_update) begin
      thr_q <= thr_d;
    end
  end

  // on/off pattern tracker
  logic [PAT_W-1:0] obs_q, obs_d;
  logic [POS_W-1:0] pos_q, pos_d, pos_n, len_c, ed_dist;
  logic             act_q, act_d, done_q, done_d, need_d, need_q;
  logic             rearm_d, rearm_q, tone_q, rec, rec_bit, ed_busy;

  always_comb begin
    if (plen_q == '0) begin
      len_c = POS_W'(1);
    end else if (plen_q > POS_W'(PAT_W)) begin
      len_c = POS_W'(PAT_W);
    end else begin
      len_c = plen_q;
    end
  end

  always_comb begin
    obs_d   = obs_q;
    pos_d   = pos_q;
    act_d   = act_q;
    done_d  = done_q;
    need_d  = 1'b0;
    rearm_d = 1'b0;
    rec     = 1'b0;
    rec_bit = 1'b0;
    pos_n   = pos_q;
    if (tone) begin
      if (!done_q) begin
        act_d   = 1'b1;
        rec     = 1'b1;
        rec_bit = 1'b1;
      end
    end else if (done_q) begin
      done_d  = 1'b0;
      act_d   = 1'b0;
      pos_d   = '0;
      obs_d   = '0;
      rearm_d = 1'b1;
    end else if (act_q) begin
      rec = 1'b1;
    end
    if (rec) begin
      if (pos_q < len_c) begin
        obs_d[pos_q[PAT_IDX_W-1:0]] = rec_bit;
        pos_n = pos_q + 1'b1;
      end
      pos_d = pos_n;
      if (pos_n >= len_c) begin
        act_d  = 1'b0;
        done_d = 1'b1;
        need_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_q   <= '0;
      pos_q   <= '0;
      act_q   <= 1'b0;
      done_q  <= 1'b0;
      need_q  <= 1'b0;
      rearm_q <= 1'b0;
      tone_q  <= 1'b0;
    end else if (blk_update) begin
      obs_q   <= obs_d;
      pos_q   <= pos_d;
      act_q   <= act_d;
      done_q  <= done_d;
      need_q  <= need_d;
      rearm_q <= rearm_d;
      tone_q  <= tone;
    end
  end

  gtd_edit u_edit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.ed_start),
    .len_i      (len_c),
    .target_i   (target_q),
    .observed_i (obs_q),
    .busy_o     (ed_busy),
    .dist_o     (ed_dist)
  );

  // output register
  logic             ov_q;
  logic             o_tone_q, o_match_q, o_miss_q, o_rearm_q;
  logic [THR_W-1:0] o_ratio_q, o_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (m_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_tone_q  <= tone_q;
      o_ratio_q <= ratio;
      o_thr_q   <= thr_q;
      o_match_q <= need_q && (ed_dist <= maxd_q);
      o_miss_q  <= need_q && (ed_dist > maxd_q);
      o_rearm_q <= rearm_q;
    end
  end

  assign m_valid_o = ov_q;
  assign tone_o    = o_tone_q;
  assign ratio_o   = o_ratio_q;
  assign thr_o     = o_thr_q;
  assign matched_o = o_match_q;
  assign missed_o  = o_miss_q;
  assign rearmed_o = o_rearm_q;

  assign status_o.blk_end  = last_q || (cnt_q == CNT_W'(MAX_BLOCK - 1));
  assign status_o.mul_busy = mbusy_q;
  assign status_o.div_busy = dbusy_q;
  assign status_o.ed_busy  = ed_busy;
  assign status_o.ed_need  = need_q;
  assign status_o.out_free = !ov_q || m_ready_i;

  a_mul_div_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mbusy_q && dbusy_q))
    else $error("multiplier and divider busy together");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!ov_q || m_ready_i))
    else $error("result word overwritten before taken");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(PAT_W))
    else $error("pattern position out of range");

  a_track_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(act_q && done_q))
    else $error("tracker active and finished at once");

endmodule

// File: rtl/gtd_ctrl.sv
module gtd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gtd_pkg::dp_status_t status_i,
  output gtd_pkg::dp_cmd_t    cmd_o
);
  import gtd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_S1S1;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d = ST_SAMP;
        end
      end
      ST_SAMP: begin
        cmd_o.upd_sample = 1'b1;
        state_d = status_i.blk_end ? ST_MS1 : ST_IDLE;
      end
      ST_MS1: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_S1S1;
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        if (!status_i.mul_busy) begin
          cmd_o.acc_load  = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_S2S2;
          state_d = ST_SQ2;
        end
      end
      ST_SQ2: begin
        if (!status_i.mul_busy) begin
          cmd_o.acc_add = 1'b1;
          cmd_o.load_cs = 1'b1;
          state_d = ST_CS;
        end
      end
      ST_CS: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_CS_S2;
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        if (!status_i.mul_busy) begin
          cmd_o.acc_sub = 1'b1;
          state_d = ST_DIVS;
        end
      end
      ST_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.blk_update = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (status_i.ed_need) begin
          cmd_o.ed_start = 1'b1;
          state_d = ST_EDIT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_EDIT: begin
        if (!status_i.ed_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/goertzel_tone_pattern_detector.sv
// Goertzel tone detector with adaptive threshold and on/off pattern matching.
// Each accepted sample word first has its coefficient and energy products
// registered, then its recurrence sums formed. A block ends on tlast or on
// the MAX_BLOCK-th sample; the block end then runs the shared shift-add
// multiplier for tone power, the restoring divider for the Q16.16 ratio,
// and, when the pattern fills, the edit distance at one DP cell per cycle.
// During block-end work no sample is taken; one result word comes out per
// block and is held in an output register, so a following block starts
// while it waits. Config writes are accepted every cycle and must only
// happen while the block is idle.
module goertzel_tone_pattern_detector #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_BLOCK   = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample
  input  logic                                   s_axis_tlast,  // last_in_block
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tone_present, power_ratio, threshold_now, pattern_matched,
  // pattern_missed, pattern_rearmed, zero pad
  output logic [gtd_pkg::OUT_W-1:0]              m_axis_tdata,
  // register writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [gtd_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [gtd_pkg::CFG_DAT_W-1:0]          cfg_data_i
);
  import gtd_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             tone, matched, missed, rearmed;
  logic [THR_W-1:0] ratio, thr;

  // registers are plain flops, always writable
  assign cfg_ready_o = 1'b1;

  gtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gtd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .tone_o      (tone),
    .ratio_o     (ratio),
    .thr_o       (thr),
    .matched_o   (matched),
    .missed_o    (missed),
    .rearmed_o   (rearmed)
  );

  // result word layout, highest bit first
  assign m_axis_tdata = {4'b0000, rearmed, missed, matched, thr, ratio, tone};

endmodule

// File: tb/tb_top.sv
module tb_top;
  import gtd_pkg::*;

  localparam int unsigned BLOCK_MAX  = 4096;
  localparam int unsigned CYCLE_CAP  = 3_000_000;
  localparam int unsigned HOLD_LEN   = 3000;
  localparam int unsigned DRAIN_WAIT = 400;

  // result word fields, lowest bit first: tone, ratio, threshold, match, miss, rearm, pad
  typedef struct packed {
    logic [3:0]  pad;
    logic        rearmed;
    logic        missed;
    logic        matched;
    logic [31:0] thr;
    logic [31:0] ratio;
    logic        tone;
  } tone_res_t;

  typedef struct {
    logic [15:0] smp;
    bit          last;
    bit          typed;
    tone_res_t   want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  goertzel_tone_pattern_detector dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic signed [15:0] coef_q;
  logic [31:0] target_q;
  logic [3:0]  shift_q;
  logic [5:0]  len_q, maxd_q;
  logic signed [47:0] acc_s1, acc_s2;
  logic [47:0] energy_q;
  int unsigned blk_cnt;
  logic [31:0] thr_q, seen_pat;
  int unsigned pat_pos;
  bit pat_active, pat_done;

  tone_res_t block_results[$];
  int unsigned n_fail, n_results, n_match, n_miss, n_rearm, n_words, n_cfg;
  longint unsigned n_cycles;
  bit quiet_mode, hold_req;

  function automatic int unsigned pattern_distance(int unsigned len);
    int unsigned prev[0:32];
    int unsigned cur[0:32];
    int unsigned best;
    for (int j = 0; j <= len; j++) prev[j] = j;
    for (int i = 1; i <= len; i++) begin
      cur[0] = i;
      for (int j = 1; j <= len; j++) begin
        best = prev[j-1] + ((target_q[i-1] != seen_pat[j-1]) ? 1 : 0);
        if (prev[j] + 1 < best) best = prev[j] + 1;
        if (cur[j-1] + 1 < best) best = cur[j-1] + 1;
        cur[j] = best;
      end
      for (int j = 0; j <= len; j++) prev[j] = cur[j];
    end
    return prev[len];
  endfunction

  // 0 nothing, 1 match, 2 miss
  function automatic int record_state(bit on, int unsigned len);
    if (pat_pos < len) begin
      seen_pat[pat_pos] = on;
      pat_pos++;
    end
    if (pat_pos >= len) begin
      pat_active = 0;
      pat_done = 1;
      return (pattern_distance(len) <= maxd_q) ? 1 : 2;
    end
    return 0;
  endfunction

  task automatic predictor_reset();
    coef_q = '0; shift_q = SHIFT_RESET;
    target_q = 32'd1; len_q = 6'd1; maxd_q = 6'd1;
    acc_s1 = '0; acc_s2 = '0; energy_q = '0; blk_cnt = 0;
    thr_q = THR_RESET; pat_pos = 0; pat_active = 0; pat_done = 0; seen_pat = '0;
  endtask

  // one sample word through the Goertzel step; has is set at block end
  task automatic goertzel_step(input logic [15:0] smp, input bit last,
                               output bit has, output tone_res_t r);
    logic signed [63:0] x, prod, s;
    logic [63:0] e;
    logic signed [127:0] a1, a2, c, pw;
    logic [127:0] num, q;
    logic [31:0] ratio;
    int unsigned k, len;
    int verdict;
    x = {{48{smp[15]}}, smp};
    prod = 64'(coef_q) * 64'(acc_s1);
    s = x + (prod >>> 14) - 64'(acc_s2);
    if (s > 64'sh0000_7FFF_FFFF_FFFF) s = 64'sh0000_7FFF_FFFF_FFFF;
    if (s < -64'sh0000_8000_0000_0000) s = -64'sh0000_8000_0000_0000;
    acc_s2 = acc_s1;
    acc_s1 = s[47:0];
    e = {16'b0, energy_q} + 64'(x * x);
    energy_q = (e > 64'h0000_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : e[47:0];
    blk_cnt++;
    has = 0;
    r = '0;
    if (!last && blk_cnt < BLOCK_MAX) return;
    has = 1;
    a1 = acc_s1; a2 = acc_s2; c = coef_q;
    pw = ((a1 * a1 + a2 * a2) <<< 14) - c * a1 * a2;
    if (energy_q == 0 || pw < 0) ratio = '0;
    else begin
      num = pw << 2;
      q = num / {80'b0, energy_q};
      ratio = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    acc_s1 = '0; acc_s2 = '0; energy_q = '0; blk_cnt = 0;
    k = (shift_q == 0) ? 1 : shift_q;
    len = (len_q == 0) ? 1 : ((len_q > 32) ? 32 : len_q);
    verdict = 0;
    if (ratio > thr_q) begin
      r.tone = 1;
      thr_q = thr_q + ((ratio - thr_q) >> (k - 1));
      if (!pat_done) begin
        pat_active = 1;
        verdict = record_state(1, len);
      end
    end else begin
      thr_q = thr_q - ((thr_q - ratio) >> k);
      if (pat_done) begin
        pat_done = 0; pat_active = 0; pat_pos = 0; seen_pat = '0;
        r.rearmed = 1;
      end else if (pat_active) begin
        verdict = record_state(0, len);
      end
    end
    r.ratio = ratio;
    r.thr = thr_q;
    r.matched = (verdict == 1);
    r.missed = (verdict == 2);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    case (idx)
      REG_COEFF:    coef_q = val[15:0];
      REG_INIT_THR: thr_q = val;
      REG_SHIFT:    shift_q = val[3:0];
      REG_TARGET:   target_q = val;
      REG_LENGTH:   len_q = val[5:0];
      REG_MAXD:     maxd_q = val[5:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // drive one sample word; typed rows override the predicted word
  task automatic send_word(logic [15:0] smp, bit last, bit typed = 0,
                           tone_res_t want = '0);
    bit has;
    tone_res_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_words++;
    goertzel_step(smp, last, has, r);
    if (has) block_results.push_back(typed ? want : r);
    if (!quiet_mode && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    @(posedge clk_i);
    while (block_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // kinds: 0 tone at the coefficient's frequency, 1 faint noise, 2 full-range noise
  task automatic send_block(int unsigned n, int kind);
    real cw, w, ph, amp, v;
    logic [15:0] smp;
    cw = real'(coef_q) / 32768.0;
    if (cw > 1.0) cw = 1.0;
    if (cw < -1.0) cw = -1.0;
    w = $acos(cw);
    ph = real'($urandom_range(0, 628)) / 100.0;
    amp = real'($urandom_range(2000, 32000));
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: begin
          v = amp * $cos(w * i + ph);
          smp = 16'($rtoi(v));
        end
        1: smp = 16'($signed($urandom_range(0, 64)) - 32);
        default: smp = 16'($urandom);
      endcase
      if (kind == 2) send_word(smp, (i == n - 1) || ($urandom_range(0, 5) == 0));
      else send_word(smp, i == n - 1);
    end
  endtask

  // result side: random stalls, plus one long hold while input keeps coming
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 0;
        m_axis_tready <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    tone_res_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      n_results++;
      if (block_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_w = block_results.pop_front();
        n_match += exp_w.matched;
        n_miss  += exp_w.missed;
        n_rearm += exp_w.rearmed;
        if (got.tone !== exp_w.tone || got.ratio !== exp_w.ratio ||
            got.thr !== exp_w.thr || got.matched !== exp_w.matched ||
            got.missed !== exp_w.missed || got.rearmed !== exp_w.rearmed ||
            got.pad !== exp_w.pad) begin
          n_fail++;
          if (n_fail <= 10)
            $display({"result %0d: exp tone %b ratio %h thr %h m/x/r %b%b%b, ",
                      "got tone %b ratio %h thr %h m/x/r %b%b%b"},
                     n_results, exp_w.tone, exp_w.ratio, exp_w.thr, exp_w.matched,
                     exp_w.missed, exp_w.rearmed, got.tone, got.ratio, got.thr,
                     got.matched, got.missed, got.rearmed);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int unsigned phase_words;
    int unsigned phase_base;
    int pick;
    predictor_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: silent blocks give ratio 0 and pull the threshold down by 1/16
    rows.push_back('{16'h0000, 1, 1, '{4'b0, 1'b0, 1'b0, 1'b0, 32'd61440, 32'd0, 1'b0}});
    rows.push_back('{16'h0000, 1, 1, '{4'b0, 1'b0, 1'b0, 1'b0, 32'd57600, 32'd0, 1'b0}});
    rows.push_back('{16'h7FFF, 0, 0, '0});
    rows.push_back('{16'h8000, 1, 0, '0});
    rows.push_back('{16'h8000, 1, 0, '0});
    rows.push_back('{16'h0001, 0, 0, '0});
    rows.push_back('{16'hFFFF, 0, 0, '0});
    rows.push_back('{16'h7FFF, 0, 0, '0});
    rows.push_back('{16'h8000, 1, 0, '0});
    rows.push_back('{16'h0000, 0, 0, '0});
    rows.push_back('{16'h5555, 0, 0, '0});
    rows.push_back('{16'hAAAA, 1, 0, '0});
    foreach (rows[i]) send_word(rows[i].smp, rows[i].last, rows[i].typed, rows[i].want);
    drain();

    // extreme coefficient, shift zero (acts as 1), length zero (acts as 1)
    cfg_write(REG_COEFF, 32'h0000_8000);
    cfg_write(REG_SHIFT, 32'd0);
    cfg_write(REG_LENGTH, 32'd0);
    cfg_write(REG_MAXD, 32'd0);
    cfg_write(REG_TARGET, 32'd0);
    cfg_write(REG_INIT_THR, 32'd0);
    send_block(8, 0);
    send_block(4, 1);
    send_block(6, 0);
    send_block(3, 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_COEFF, 32'($urandom_range(0, 65535)));
          cfg_write(REG_INIT_THR, 32'hFFFF_FFFF);
          cfg_write(REG_SHIFT, 32'd15);
          cfg_write(REG_TARGET, 32'hFFFF_FFFF);
          cfg_write(REG_LENGTH, 32'd63);
          cfg_write(REG_MAXD, 32'd63);
        end
        1: begin
          cfg_write(REG_COEFF, 32'h0000_4000);
          cfg_write(REG_INIT_THR, 32'h0004_0000);
          cfg_write(REG_SHIFT, 32'd1);
          cfg_write(REG_LENGTH, 32'd32);
          cfg_write(REG_MAXD, 32'd32);
          hold_req = 1;
        end
        default: begin
          cfg_write(REG_COEFF, 32'($urandom_range(0, 65535)));
          cfg_write(REG_INIT_THR, $urandom_range(0, 32'h0010_0000));
          cfg_write(REG_SHIFT, $urandom_range(1, 15));
          cfg_write(REG_TARGET, $urandom);
          cfg_write(REG_LENGTH, $urandom_range(1, 8));
          cfg_write(REG_MAXD, $urandom_range(0, 3));
        end
      endcase
      quiet_mode = (ph == 5);
      phase_base = n_words;
      phase_words = 0;
      while (phase_words < 175) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          send_block($urandom_range(1, 12), 0);
        end else if (pick < 9) begin
          send_block($urandom_range(1, 8), 1);
        end else begin
          send_block($urandom_range(1, 10), 2);
        end
        phase_words = n_words - phase_base;
      end
      drain();
    end

    $display("words %0d, configuration writes %0d, result words %0d",
             n_words, n_cfg, n_results);
    $display("pattern matches %0d, misses %0d, rearms %0d", n_match, n_miss, n_rearm);
    if (n_fail == 0 && block_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
